// ===== rtl/car_pkg.sv =====
// ----------------------------------------------------------------------------
// car_pkg
// Shared constants for the cosine annealing rate pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package car_pkg;
	localparam logic [31:0] PI_Q30   = 32'd3373259426;
	localparam logic [31:0] GAIN_Q30 = 32'd652032874;
	localparam logic [31:0] ONE_Q30  = 32'd1073741824;
	localparam logic [1:0] REG_MAX = 2'd0;
	localparam logic [1:0] REG_MIN = 2'd1;
	localparam logic [1:0] REG_LEN = 2'd2;

	function automatic logic signed [33:0] atan_q30(input logic [4:0] k);
		logic [29:0] v;
		case (k)
			5'd0: v = 30'd843314856;
			5'd1: v = 30'd497837829;
			5'd2: v = 30'd263043836;
			5'd3: v = 30'd133525158;
			5'd4: v = 30'd67021686;
			5'd5: v = 30'd33543515;
			5'd6: v = 30'd16775850;
			5'd7: v = 30'd8388437;
			5'd8: v = 30'd4194282;
			5'd9: v = 30'd2097149;
			5'd10: v = 30'd1048575;
			5'd11: v = 30'd524287;
			5'd12: v = 30'd262143;
			5'd13: v = 30'd131071;
			5'd14: v = 30'd65535;
			5'd15: v = 30'd32767;
			5'd16: v = 30'd16383;
			5'd17: v = 30'd8191;
			5'd18: v = 30'd4095;
			5'd19: v = 30'd2047;
			5'd20: v = 30'd1023;
			5'd21: v = 30'd511;
			5'd22: v = 30'd255;
			5'd23: v = 30'd127;
			5'd24: v = 30'd63;
			5'd25: v = 30'd31;
			5'd26: v = 30'd15;
			5'd27: v = 30'd7;
			5'd28: v = 30'd3;
			5'd29: v = 30'd1;
			default: v = 30'd0;
		endcase
		return {4'd0, v};
	endfunction
endpackage
`default_nettype wire

// ===== rtl/car_div.sv =====
// ----------------------------------------------------------------------------
// car_div
// Pipelined restoring divider: p = floor(e * 2^32 / len), one quotient bit
// per stage, an item entering every cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module car_div #(
	parameter int EB = 24
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	input  wire logic [EB-1:0] num,
	input  wire logic [EB-1:0] den,
	output logic               out_valid,
	output logic [31:0]        quo
);
	localparam int NB = EB + 32;

	logic          v_s [NB+1];
	logic [EB:0]   r_s [NB+1];
	logic [NB-1:0] n_s [NB+1];
	logic [EB-1:0] d_s [NB+1];

	always_comb begin
		v_s[0] = in_valid;
		r_s[0] = '0;
		n_s[0] = {num, 32'd0};
		d_s[0] = den;
	end

	for (genvar i = 0; i < NB; i++) begin : g_st
		logic [EB+1:0] tr;
		logic [EB+1:0] df;
		assign tr = {r_s[i], n_s[i][NB-1]};
		assign df = tr - {2'b00, d_s[i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			d_s[i+1] <= d_s[i];
			if (!df[EB+1]) begin
				r_s[i+1] <= df[EB:0];
				n_s[i+1] <= {n_s[i][NB-2:0], 1'b1};
			end else begin
				r_s[i+1] <= tr[EB:0];
				n_s[i+1] <= {n_s[i][NB-2:0], 1'b0};
			end
		end
	end

	assign out_valid = v_s[NB];
	assign quo = n_s[NB][31:0];
endmodule
`default_nettype wire

// ===== rtl/car_cordic.sv =====
// ----------------------------------------------------------------------------
// car_cordic
// Angle scaling followed by a pipelined rotation-mode CORDIC returning sine.
// ----------------------------------------------------------------------------
`default_nettype none
module car_cordic #(
	parameter int STAGES = 24
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic [31:0]        prog,
	output logic                    out_valid,
	output logic signed [33:0]      sin_q30
);
	import car_pkg::*;

	logic               v_m;
	logic signed [63:0] prod_m;
	logic               v_s [STAGES+1];
	logic signed [33:0] x_s [STAGES+1];
	logic signed [33:0] y_s [STAGES+1];
	logic signed [33:0] z_s [STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m <= 1'b0;
			v_s[0] <= 1'b0;
		end else begin
			v_m <= in_valid;
			v_s[0] <= v_m;
		end
	end

	always_ff @(posedge clk) begin
		prod_m <= 64'(signed'({~prog[31], prog[30:0]})) * signed'({32'd0, PI_Q30});
		x_s[0] <= signed'({2'b00, GAIN_Q30});
		y_s[0] <= '0;
		z_s[0] <= 34'(prod_m >>> 32);
	end

	for (genvar i = 0; i < STAGES; i++) begin : g_st
		localparam logic [4:0] K = 5'(i);
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[i+1] <= 1'b0;
			end else begin
				v_s[i+1] <= v_s[i];
			end
		end
		always_ff @(posedge clk) begin
			if (!z_s[i][33]) begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> K);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> K);
				z_s[i+1] <= z_s[i] - atan_q30(K);
			end else begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> K);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> K);
				z_s[i+1] <= z_s[i] + atan_q30(K);
			end
		end
	end

	assign out_valid = v_s[STAGES];
	assign sin_q30 = y_s[STAGES];
endmodule
`default_nettype wire

// ===== rtl/car_interp.sv =====
// ----------------------------------------------------------------------------
// car_interp
// Forms the cosine weight and interpolates between the two rates.
// ----------------------------------------------------------------------------
`default_nettype none
module car_interp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic signed [33:0] sin_q30,
	input  wire logic [31:0]        max_rate,
	input  wire logic [31:0]        min_rate,
	output logic                    out_valid,
	output logic [31:0]             rate
);
	import car_pkg::*;

	logic signed [34:0] half;
	logic [30:0]        c;
	logic               v_s1, v_s2, v_s3;
	logic [30:0]        c_s1;
	logic signed [32:0] d_s1;
	logic [31:0]        mn_s1, mn_s2;
	logic signed [64:0] p_s2;
	logic [31:0]        r_s3;

	always_comb begin
		half = (35'(signed'({1'b0, ONE_Q30})) - 35'(sin_q30)) >>> 1;
		if (half < 0) begin
			c = '0;
		end else if (half > 35'(signed'({1'b0, ONE_Q30}))) begin
			c = 31'(ONE_Q30);
		end else begin
			c = half[30:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		c_s1  <= c;
		d_s1  <= signed'({1'b0, max_rate}) - signed'({1'b0, min_rate});
		mn_s1 <= min_rate;
		p_s2  <= 65'(d_s1) * 65'(signed'({1'b0, c_s1})) + 65'sd536870912;
		mn_s2 <= mn_s1;
		r_s3  <= mn_s2 + 32'(p_s2 >>> 30);
	end

	assign out_valid = v_s3;
	assign rate = r_s3;
endmodule
`default_nettype wire

// ===== rtl/cosine_annealing_rate.sv =====
// ----------------------------------------------------------------------------
// cosine_annealing_rate
// Cosine annealing learning rate schedule, unsigned Q1.31 rates.
//
// Channel   Signals                               Direction
// command   start, busy, epoch                    in
// result    done, rate                            out
// config    cfg_valid, cfg_ready, cfg_index, cfg_data   in
//
// One epoch is accepted every cycle; busy stays low. A result passes
// through the input register, the bit-per-stage divider, the angle scaling
// and CORDIC stages and the interpolation stages. Reset clears all valid
// bits and loads the register defaults.
// The receiver takes each result in its done cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module cosine_annealing_rate #(
	parameter int CORDIC_STAGES = 24,
	parameter int EPOCH_BITS = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [24:0] epoch,
	output logic             done,
	output logic [31:0]      rate,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [31:0] cfg_data
);
	import car_pkg::*;

	localparam int EB = EPOCH_BITS;

	logic [31:0]   max_q, min_q;
	logic [23:0]   len_q;
	logic [EB-1:0] lenm, len_s1, e_s1;
	logic [EB+24:0] ext;
	logic          v_s1;
	logic          dv;
	logic [31:0]   pq;
	logic          cv;
	logic signed [33:0] sn;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= 32'd214748365;
			min_q <= 32'd0;
			len_q <= 24'd100;
			v_s1  <= 1'b0;
		end else begin
			v_s1 <= start;
			if (cfg_valid) begin
				case (cfg_index)
					REG_MAX: max_q <= cfg_data;
					REG_MIN: min_q <= cfg_data;
					REG_LEN: len_q <= cfg_data[23:0];
					default: ;
				endcase
			end
		end
	end

	always_comb begin
		ext  = {{(EB+1){1'b0}}, len_q};
		lenm = ext[EB-1:0];
		if (lenm == '0) lenm = EB'(1);
	end

	always_ff @(posedge clk) begin
		logic [EB+24:0] ee;
		logic [EB-1:0]  ec;
		ee = {{EB{1'b0}}, epoch};
		if (epoch[24]) begin
			ec = '0;
		end else if ({{EB{1'b0}}, epoch} >= {25'd0, lenm}) begin
			ec = lenm - EB'(1);
		end else begin
			ec = ee[EB-1:0];
		end
		e_s1   <= ec;
		len_s1 <= lenm;
	end

	car_div #(.EB(EB)) u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s1), .num(e_s1), .den(len_s1),
		.out_valid(dv), .quo(pq)
	);

	car_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
		.clk(clk), .arst_n(arst_n), .in_valid(dv), .prog(pq),
		.out_valid(cv), .sin_q30(sn)
	);

	car_interp u_interp (
		.clk(clk), .arst_n(arst_n), .in_valid(cv), .sin_q30(sn),
		.max_rate(max_q), .min_rate(min_q), .out_valid(done), .rate(rate)
	);
endmodule
`default_nettype wire
